// ===== design/sdcsd_pkg.sv =====
package sdcsd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_TYPE    = 2'd1,
    STATUS_BAD_VERSION = 2'd2,
    STATUS_BAD_STRUCT  = 2'd3
  } status_t;

  localparam logic [2:0] CARD_MMC  = 3'd0;
  localparam logic [2:0] CARD_SDHC = 3'd3;

  localparam logic [1:0] CSD_STRUCT_V1 = 2'd0;
  localparam logic [1:0] CSD_STRUCT_V2 = 2'd1;
  localparam logic [1:0] CSD_STRUCT_V3 = 2'd2;
  localparam logic [3:0] MMC_SPEC_MAX  = 4'd4;

  // floor(x / 10) via (x * ceil(2^35 / 10)) >> 35, exact for x below 2^32
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // decoded csd fields handed from the field decoder to the pipeline
  typedef struct packed {
    status_t     status;
    logic        wide;
    logic [11:0] ccc;
    logic [23:0] rate_unit;
    logic [6:0]  rate_mant;
    logic [23:0] time_unit;
    logic [6:0]  time_mant;
    logic [7:0]  nsac;
    logic [2:0]  r2w;
    logic [3:0]  rbl;
    logic [3:0]  wbl;
    logic [3:0]  flags;
    logic [11:0] c_size;
    logic [2:0]  c_mult;
    logic [21:0] c_size_hc;
  } csd_fields_t;

  function automatic logic [23:0] rate_unit_lut(input logic [2:0] e);
    logic [23:0] r;
    unique case (e)
      3'd0:    r = 24'd10000;
      3'd1:    r = 24'd100000;
      3'd2:    r = 24'd1000000;
      3'd3:    r = 24'd10000000;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] time_unit_lut(input logic [2:0] e);
    logic [23:0] r;
    unique case (e)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] mant_lut(input logic [3:0] m);
    logic [6:0] r;
    unique case (m)
      4'd0:    r = 7'd0;
      4'd1:    r = 7'd10;
      4'd2:    r = 7'd12;
      4'd3:    r = 7'd13;
      4'd4:    r = 7'd15;
      4'd5:    r = 7'd20;
      4'd6:    r = 7'd25;
      4'd7:    r = 7'd30;
      4'd8:    r = 7'd35;
      4'd9:    r = 7'd40;
      4'd10:   r = 7'd45;
      4'd11:   r = 7'd50;
      4'd12:   r = 7'd55;
      4'd13:   r = 7'd60;
      4'd14:   r = 7'd70;
      default: r = 7'd80;
    endcase
    return r;
  endfunction

endpackage

// ===== design/sd_mmc_csd_decoder_core.sv =====
// csd register decoder, three-stage pipeline: decode, multiply, divide and shift
// an accepted item moves through the stage-one, stage-two and stage-three registers in turn to result_valid
// throughput: one item per cycle; each stage holds under stall and refills bubbles
// the stage-three reciprocal multiply for the divide by ten sets the cycle depth
// reset (synchronous, active high) empties all stages; data registers are not reset
module sd_mmc_csd_decoder_core
  import sdcsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  card_type,
  input  logic [63:0] csd_high,
  input  logic [63:0] csd_low,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [11:0] command_classes,
  output logic [26:0] access_time_ns,
  output logic [14:0] access_time_clocks,
  output logic [2:0]  write_speed_factor,
  output logic [29:0] max_rate,
  output logic [3:0]  read_block_log2,
  output logic [3:0]  write_block_log2,
  output logic [3:0]  access_flags,
  output logic [32:0] block_count,
  output logic [47:0] capacity_bytes
);

  csd_fields_t dec_fields;
  csd_fields_t s1;
  logic        v1, v2, v3;
  logic        adv1, adv2, adv3;

  // stage two registers
  logic        s2_ok;
  status_t     s2_status;
  logic [11:0] s2_ccc;
  logic [29:0] s2_rate;
  logic [29:0] s2_time_sum;
  logic [14:0] s2_clocks;
  logic [2:0]  s2_r2w;
  logic [3:0]  s2_rbl;
  logic [3:0]  s2_wbl;
  logic [3:0]  s2_flags;
  logic [32:0] s2_bc;

  logic [30:0] rate_prod;
  logic [30:0] time_prod;
  logic [14:0] clocks_prod;
  logic [3:0]  mult_shift;
  logic [32:0] bc_v1;
  logic [32:0] bc_v2;
  logic [61:0] div_prod;
  logic [26:0] div_q;
  logic [47:0] cap_shift;

  sdcsd_field_decode u_decode (
    .card_type (card_type),
    .csd_high  (csd_high),
    .csd_low   (csd_low),
    .fields    (dec_fields)
  );

  assign adv3       = !v3 || !result_stall;
  assign adv2       = !v2 || adv3;
  assign adv1       = !v1 || adv2;
  assign item_stall = !adv1;
  assign result_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= item_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage one: decoded fields
  always_ff @(posedge clk) begin
    if (adv1 && item_valid) begin
      s1 <= dec_fields;
    end
  end

  // stage two: table products and block count
  assign rate_prod   = 31'(s1.rate_unit) * 31'(s1.rate_mant);
  assign time_prod   = 31'(s1.time_unit) * 31'(s1.time_mant) + 31'd9;
  assign clocks_prod = 15'(s1.nsac) * 15'd100;
  assign mult_shift  = {1'b0, s1.c_mult} + 4'd2;
  assign bc_v1       = (33'(s1.c_size) + 33'd1) << mult_shift;
  assign bc_v2       = (33'(s1.c_size_hc) + 33'd1) << 10;

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      s2_ok       <= (s1.status == STATUS_OK);
      s2_status   <= s1.status;
      s2_ccc      <= s1.ccc;
      s2_rate     <= rate_prod[29:0];
      s2_time_sum <= time_prod[29:0];
      s2_clocks   <= clocks_prod;
      s2_r2w      <= s1.r2w;
      s2_rbl      <= s1.rbl;
      s2_wbl      <= s1.wbl;
      s2_flags    <= s1.flags;
      s2_bc       <= s1.wide ? bc_v2 : bc_v1;
    end
  end

  // stage three: divide by ten and byte capacity, error records cleared
  assign div_prod  = 62'(s2_time_sum) * 62'(DIV10_RECIP);
  assign div_q     = div_prod[61:DIV10_SHIFT];
  assign cap_shift = 48'(s2_bc) << s2_rbl;

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      status <= s2_status;
      if (s2_ok) begin
        command_classes    <= s2_ccc;
        access_time_ns     <= div_q;
        access_time_clocks <= s2_clocks;
        write_speed_factor <= s2_r2w;
        max_rate           <= s2_rate;
        read_block_log2    <= s2_rbl;
        write_block_log2   <= s2_wbl;
        access_flags       <= s2_flags;
        block_count        <= s2_bc;
        capacity_bytes     <= cap_shift;
      end else begin
        command_classes    <= '0;
        access_time_ns     <= '0;
        access_time_clocks <= '0;
        write_speed_factor <= '0;
        max_rate           <= '0;
        read_block_log2    <= '0;
        write_block_log2   <= '0;
        access_flags       <= '0;
        block_count        <= '0;
        capacity_bytes     <= '0;
      end
    end
  end

endmodule

// ===== design/sdcsd_field_decode.sv =====
module sdcsd_field_decode
  import sdcsd_pkg::*;
(
  input  logic [2:0]  card_type,
  input  logic [63:0] csd_high,
  input  logic [63:0] csd_low,
  output csd_fields_t fields
);

  logic [127:0] csd;
  logic [1:0]   st;
  logic         is_wide;
  status_t      stat;

  assign csd = {csd_high, csd_low};
  assign st  = csd[127:126];

  always_comb begin
    stat    = STATUS_OK;
    is_wide = 1'b0;
    if (card_type == CARD_MMC) begin
      if (csd[125:122] > MMC_SPEC_MAX) begin
        stat = STATUS_BAD_VERSION;
      end else if (st != CSD_STRUCT_V2 && st != CSD_STRUCT_V3) begin
        stat = STATUS_BAD_STRUCT;
      end
    end else if (card_type <= CARD_SDHC) begin
      if (st == CSD_STRUCT_V2) begin
        is_wide = 1'b1;
      end else if (st != CSD_STRUCT_V1) begin
        stat = STATUS_BAD_STRUCT;
      end
    end else begin
      stat = STATUS_BAD_TYPE;
    end
  end

  always_comb begin
    fields.status    = stat;
    fields.wide      = is_wide;
    fields.ccc       = csd[95:84];
    fields.rate_unit = rate_unit_lut(csd[98:96]);
    fields.rate_mant = mant_lut(csd[102:99]);
    fields.c_size    = csd[73:62];
    fields.c_mult    = csd[49:47];
    fields.c_size_hc = csd[69:48];
    fields.time_unit = time_unit_lut(csd[114:112]);
    if (is_wide) begin
      // v2.0 layout has fixed timing and block sizes
      fields.time_mant = 7'd0;
      fields.nsac      = 8'd0;
      fields.r2w       = 3'd4;
      fields.rbl       = 4'd9;
      fields.wbl       = 4'd9;
      fields.flags     = 4'd0;
    end else begin
      fields.time_mant = mant_lut(csd[118:115]);
      fields.nsac      = csd[111:104];
      fields.r2w       = csd[28:26];
      fields.rbl       = csd[83:80];
      fields.wbl       = csd[25:22];
      fields.flags     = {csd[21], csd[78], csd[77], csd[79]};
    end
  end

endmodule
